FILE: rtl/crfm_pkg.sv
package crfm_pkg;

  localparam int unsigned MAX_RANGES = 64;
  localparam int unsigned ID_BITS = 4;
  localparam int unsigned CP_BITS = 21;
  localparam int unsigned IDX_W = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_COMPRESS = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  typedef struct packed {
    logic [CP_BITS-1:0] first;
    logic [CP_BITS-1:0] last;
    logic [ID_BITS-1:0] id;
  } entry_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [CP_BITS-1:0] range_first;
    logic [CP_BITS-1:0] range_last;
    logic [ID_BITS-1:0] font_id;
    logic [CP_BITS-1:0] code_point;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [ID_BITS-1:0] subset;
    logic               status;
    logic [CNT_W-1:0]   used_entries;
  } out_t;

  typedef struct packed {
    logic               ins;
    logic               shl;
    logic               wr;
    logic [CNT_W-1:0]   wr_idx;
    logic [CNT_W-1:0]   count;
    logic [CP_BITS-1:0] key;
    entry_t             new_e;
  } ctl_t;

  typedef struct packed {
    entry_t ent;
    logic   lt;
    logic   gt;
    logic   cov;
  } cell_st_t;

endpackage

FILE: rtl/crfm_cell.sv
module crfm_cell
  import crfm_pkg::*;
(
  input  logic                 clk_i,
  input  ctl_t                 ctl_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  entry_t               prev_i,
  input  logic                 prev_lt_i,
  input  entry_t               next_i,
  output cell_st_t             st_o
);

  entry_t ent_q, ent_d;
  logic   valid;

  assign valid = {1'b0, idx_i} < ctl_i.count;
  assign st_o.ent = ent_q;
  assign st_o.lt  = valid && (ent_q.first < ctl_i.key);
  assign st_o.gt  = valid && (ent_q.first > ctl_i.key);
  assign st_o.cov = valid && (ent_q.first <= ctl_i.key) && (ctl_i.key <= ent_q.last);

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.ins) begin
      if (!st_o.lt) begin
        ent_d = prev_lt_i ? ctl_i.new_e : prev_i;
      end
    end
    if (ctl_i.shl) begin
      ent_d = next_i;
    end
    if (ctl_i.wr && ({1'b0, idx_i} == ctl_i.wr_idx)) begin
      ent_d = ctl_i.new_e;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

FILE: rtl/codepoint_range_font_map_top.sv
// Lookup: one compare pass over the cell row in S_LOOK, then the result is registered.
// Insert: S_INS walks the range over each covered block or inserted part, then the result is registered.
// Compress: the table streams once through the row in S_CMP, then the result is registered.
// Compress of an empty table and an unknown action: result in the cycle after start.
// One transaction at a time; busy drops with the result strobe, next start taken then.
// Reset (async, active low) empties the table; entry contents stay unreset.
module codepoint_range_font_map_top
  import crfm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  cmd_i,
  output logic res_valid_o,
  output out_t res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_LOOK = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CP_BITS:0]   cur_q, cur_d;
  logic [CP_BITS-1:0] last_q, last_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   r_q, r_d;
  logic [CNT_W-1:0]   o_q, o_d;
  entry_t             acc_q, acc_d;
  logic               accv_q, accv_d;
  logic               vld_q, vld_d;
  out_t               res_q, res_d;

  ctl_t               ctl;
  cell_st_t           st [MAX_RANGES];
  logic [MAX_RANGES-1:0] cov_v, nxt_v;

  logic               hit;
  logic [ID_BITS-1:0] hit_id;
  logic [CP_BITS-1:0] hit_last;
  logic               has_nxt;
  logic [CP_BITS-1:0] nf;
  logic [CP_BITS-1:0] ghi;

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_lt;
    if (i == 0) begin : g_first
      assign prev_e  = st[0].ent;
      assign prev_lt = 1'b1;
      assign nxt_v[i] = st[i].gt;
    end else begin : g_mid
      assign prev_e  = st[i-1].ent;
      assign prev_lt = st[i-1].lt;
      assign nxt_v[i] = st[i].gt && !st[i-1].gt;
    end
    if (i == MAX_RANGES - 1) begin : g_last
      assign next_e = st[i].ent;
    end else begin : g_inner
      assign next_e = st[i+1].ent;
    end
    assign cov_v[i] = st[i].cov;

    crfm_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .idx_i     (IDX_W'(i)),
      .prev_i    (prev_e),
      .prev_lt_i (prev_lt),
      .next_i    (next_e),
      .st_o      (st[i])
    );
  end

  always_comb begin
    hit_id   = '0;
    hit_last = '0;
    nf       = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      hit_id   = hit_id | (st[i].ent.id & {ID_BITS{cov_v[i]}});
      hit_last = hit_last | (st[i].ent.last & {CP_BITS{cov_v[i]}});
      nf       = nf | (st[i].ent.first & {CP_BITS{nxt_v[i]}});
    end
  end

  assign hit     = |cov_v;
  assign has_nxt = |nxt_v;
  assign ghi     = (has_nxt && (nf <= last_q)) ? nf - 1'b1 : last_q;

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    last_d  = last_q;
    id_d    = id_q;
    cnt_d   = cnt_q;
    r_d     = r_q;
    o_d     = o_q;
    acc_d   = acc_q;
    accv_d  = accv_q;
    vld_d   = 1'b0;
    res_d   = res_q;
    ctl        = '0;
    ctl.count  = cnt_q;
    ctl.key    = cur_q[CP_BITS-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          res_d = '0;
          res_d.used_entries = cnt_q;
          cur_d  = {1'b0, cmd_i.range_first};
          last_d = cmd_i.range_last;
          id_d   = cmd_i.font_id;
          r_d    = cnt_q;
          o_d    = '0;
          accv_d = 1'b0;
          case (cmd_i.action)
            ACT_INSERT: state_d = S_INS;
            ACT_COMPRESS: begin
              if (cnt_q != '0) begin
                state_d = S_CMP;
              end else begin
                vld_d = 1'b1;
              end
            end
            ACT_LOOKUP: begin
              cur_d   = {1'b0, cmd_i.code_point};
              state_d = S_LOOK;
            end
            default: vld_d = 1'b1;
          endcase
        end
      end
      S_INS: begin
        if (cur_q > {1'b0, last_q}) begin
          state_d = S_IDLE;
          vld_d   = 1'b1;
        end else if (hit) begin
          cur_d = {1'b0, hit_last} + 1'b1;
        end else if (cnt_q == CNT_W'(MAX_RANGES)) begin
          res_d.status = 1'b1;
          state_d      = S_IDLE;
          vld_d        = 1'b1;
        end else begin
          ctl.ins   = 1'b1;
          ctl.new_e = '{first: cur_q[CP_BITS-1:0], last: ghi, id: id_q};
          cnt_d     = cnt_q + 1'b1;
          res_d.used_entries = cnt_q + 1'b1;
          cur_d     = {1'b0, ghi} + 1'b1;
        end
      end
      S_CMP: begin
        if (r_q != '0) begin
          ctl.shl = 1'b1;
          if (accv_q && (st[0].ent.id == acc_q.id)) begin
            acc_d.last = st[0].ent.last;
          end else begin
            if (accv_q) begin
              ctl.wr     = 1'b1;
              ctl.wr_idx = r_q - 1'b1 + o_q;
              ctl.new_e  = acc_q;
              o_d        = o_q + 1'b1;
            end
            acc_d  = st[0].ent;
            accv_d = 1'b1;
          end
          r_d = r_q - 1'b1;
        end else begin
          ctl.wr     = 1'b1;
          ctl.wr_idx = o_q;
          ctl.new_e  = acc_q;
          cnt_d      = o_q + 1'b1;
          res_d.used_entries = o_q + 1'b1;
          state_d    = S_IDLE;
          vld_d      = 1'b1;
        end
      end
      S_LOOK: begin
        res_d.found  = hit;
        res_d.subset = hit_id;
        state_d      = S_IDLE;
        vld_d        = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
      accv_q  <= 1'b0;
      r_q     <= '0;
      o_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
      accv_q  <= accv_d;
      r_q     <= r_d;
      o_q     <= o_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    last_q <= last_d;
    id_q   <= id_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign busy        = state_q != S_IDLE;
  assign res_valid_o = vld_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RANGES)) else $error("entry count overflow");
  a_used_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> res_q.used_entries == cnt_q) else $error("used_entries mismatch");
  a_cov_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CMP |-> $onehot0(cov_v)) else $error("overlapping ranges");
  a_nxt_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS |-> $onehot0(nxt_v)) else $error("table not sorted");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> !busy) else $error("result while busy");
`endif

endmodule
